@@ src/fcull_pkg.sv @@
// Shared constants, types and stage indexes for the frustum cull test block.
package fcull_pkg;

  localparam int COORD_BITS    = 16;
  localparam int HALF_BITS     = COORD_BITS - 1;
  localparam int NORM_BITS     = 16;
  localparam int FRAC_SHIFT    = 14;
  localparam int NUM_PLANES    = 6;
  localparam int NUM_AXES      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 4 * NORM_BITS;
  localparam int PROD_BITS     = COORD_BITS + NORM_BITS;
  localparam int OFS_BITS      = NORM_BITS + FRAC_SHIFT;
  localparam int DIST_BITS     = ((PROD_BITS > OFS_BITS) ? PROD_BITS : OFS_BITS) + 2;

  // Pipeline stages: multiply, sum, compare, output register.
  localparam int NUM_STAGES = 4;
  localparam int STG_MUL    = 0;
  localparam int STG_SUM    = 1;
  localparam int STG_CMP    = 2;
  localparam int STG_OUT    = 3;

  typedef logic signed [NORM_BITS-1:0] norm_t;

  typedef struct packed {
    norm_t d;
    norm_t nz;
    norm_t ny;
    norm_t nx;
  } plane_t;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctl_t;

endpackage

@@ src/fcull_if.sv @@
// Handshake interfaces for the item, result and register write channels.
interface fcull_item_if;
  import fcull_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic [HALF_BITS-1:0]         radius;
  logic [HALF_BITS-1:0]         half_x;
  logic [HALF_BITS-1:0]         half_y;
  logic [HALF_BITS-1:0]         half_z;

  modport source (output valid, operation, center_x, center_y, center_z, radius,
                  half_x, half_y, half_z, input ready);
  modport sink (input valid, operation, center_x, center_y, center_z, radius,
                half_x, half_y, half_z, output ready);
endinterface

interface fcull_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

interface fcull_cfg_if;
  import fcull_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/fcull_cfg_regs.sv @@
// Plane register file written through the configuration channel.
module fcull_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcull_cfg_if.sink         cfg_i,
  output fcull_pkg::plane_t planes_o [fcull_pkg::NUM_PLANES]
);
  import fcull_pkg::*;

  plane_t plane_q [NUM_PLANES];

  assign cfg_i.ready = 1'b1;

  // Writes to indexes past the last plane are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_BITS'(NUM_PLANES))) begin
      plane_q[cfg_i.index] <= plane_t'(cfg_i.data);
    end
  end

  assign planes_o = plane_q;

endmodule

@@ src/fcull_pipe_ctl.sv @@
// Valid tracking and per-stage load enables for the elastic test pipeline.
module fcull_pipe_ctl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output fcull_pkg::pipe_ctl_t ctl_o
);
  import fcull_pkg::*;

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] ld;

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (k == 0) begin
        ld[k]    = rdy[k] && in_valid_i;
        vld_d[k] = rdy[k] ? in_valid_i : vld_q[k];
      end else begin
        ld[k]    = rdy[k] && vld_q[k-1];
        vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctl_o.ld   = ld;
  assign ctl_o.vld  = vld_q;

  a_accept_fills_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[STG_MUL])
    else $error("accepted word did not enter the multiply stage");

  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[STG_OUT] |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  a_cmp_moves_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STG_CMP] && !vld_q[STG_OUT] |=> vld_q[STG_OUT])
    else $error("compare stage word lost on the way to the output");

endmodule

@@ src/fcull_plane_lane.sv @@
// One plane's lane: products, distance and margin sums, and the two sign tests.
module fcull_plane_lane (
  input  logic                                clk_i,
  input  fcull_pkg::pipe_ctl_t                ctl_i,
  input  fcull_pkg::plane_t                   plane_i,
  input  logic signed [fcull_pkg::COORD_BITS-1:0] center_i [fcull_pkg::NUM_AXES],
  input  logic [fcull_pkg::HALF_BITS-1:0]     half_i [fcull_pkg::NUM_AXES],
  input  logic [1:0]                          op_i,
  input  logic [fcull_pkg::HALF_BITS-1:0]     radius_i,
  output logic                                outside_o,
  output logic                                cross_o
);
  import fcull_pkg::*;

  norm_t                       norm [NUM_AXES];
  logic [NORM_BITS:0]          norm_abs [NUM_AXES];
  logic signed [PROD_BITS-1:0] prod_d [NUM_AXES];
  logic signed [PROD_BITS-1:0] prod_q [NUM_AXES];
  logic [PROD_BITS-1:0]        mag_d [NUM_AXES];
  logic [PROD_BITS-1:0]        mag_q [NUM_AXES];
  logic signed [DIST_BITS-1:0] dist_d, dist_q;
  logic [DIST_BITS-1:0]        spread;
  logic [DIST_BITS-1:0]        margin_d, margin_q;
  logic [DIST_BITS:0]          far_sum, near_sum;
  logic                        outside_q, cross_q;

  assign norm[0] = plane_i.nx;
  assign norm[1] = plane_i.ny;
  assign norm[2] = plane_i.nz;

  // Multiply stage: center products and magnitudes of the half-extent products.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      norm_abs[a] = norm[a][NORM_BITS-1] ? (NORM_BITS+1)'(-(NORM_BITS+1)'(norm[a]))
                                         : (NORM_BITS+1)'(norm[a]);
      prod_d[a]   = PROD_BITS'(norm[a]) * PROD_BITS'(center_i[a]);
      mag_d[a]    = PROD_BITS'(norm_abs[a]) * PROD_BITS'(half_i[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[STG_MUL]) begin
      prod_q <= prod_d;
      mag_q  <= mag_d;
    end
  end

  // Sum stage. The box's nearest and farthest corners sit at the center
  // distance minus and plus the summed magnitudes.
  always_comb begin
    dist_d = DIST_BITS'(prod_q[0]) + DIST_BITS'(prod_q[1]) + DIST_BITS'(prod_q[2])
           + (DIST_BITS'(plane_i.d) <<< FRAC_SHIFT);
    spread = DIST_BITS'(mag_q[0]) + DIST_BITS'(mag_q[1]) + DIST_BITS'(mag_q[2]);
    case (op_i)
      OP_POINT:  margin_d = '0;
      OP_SPHERE: margin_d = DIST_BITS'(radius_i) << FRAC_SHIFT;
      OP_BOX:    margin_d = spread;
      default:   margin_d = spread;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[STG_SUM]) begin
      dist_q   <= dist_d;
      margin_q <= margin_d;
    end
  end

  // Compare stage: sign of distance plus and minus the margin.
  assign far_sum  = {dist_q[DIST_BITS-1], dist_q} + {1'b0, margin_q};
  assign near_sum = {dist_q[DIST_BITS-1], dist_q} - {1'b0, margin_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[STG_CMP]) begin
      outside_q <= far_sum[DIST_BITS];
      cross_q   <= near_sum[DIST_BITS];
    end
  end

  assign outside_o = outside_q;
  assign cross_o   = cross_q;

  a_outside_implies_cross : assert property (@(posedge clk_i)
    ctl_i.vld[STG_CMP] |-> !(outside_q && !cross_q))
    else $error("plane reports outside without its near side behind it");

endmodule

@@ src/frustum_cull_test_core.sv @@
// Top level of the six-plane frustum cull test: registers, lanes and output stage.
//
// Usage: software loads six planes over cfg_i (index 0..5 = near, far, top,
// bottom, left, right), each word packing nx, ny, nz as signed Q1.14 and d as
// signed Q16.0 from bit 0 upward. Writes to other indexes are ignored, and the
// planes should only change while no test is in flight. Each word on item_i
// asks for one test (point, sphere or box, operation code 3 runs the box test)
// and produces exactly one verdict word on result_o: inside, intersect or
// outside, with outside winning over intersect.
//
// The pipeline has four register stages: multiply, sum, compare and the
// output register. The verdict is offered on result_o from the output
// register once its item has passed the multiply, sum and compare stages.
// One item is accepted every cycle while result_o is ready.
//
// Reset clears all stage valid bits and sets every plane to zero, where an
// all-zero plane never rejects anything. When the receiver holds result_o
// ready low, the verdict stays in the output register and the stages behind it
// keep filling until each holds a word; then item_i ready drops. No word is
// dropped or repeated.
module frustum_cull_test_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  fcull_cfg_if.sink      cfg_i,
  fcull_item_if.sink     item_i,
  fcull_result_if.source result_o
);
  import fcull_pkg::*;

  plane_t                       planes [NUM_PLANES];
  pipe_ctl_t                    ctl;
  logic signed [COORD_BITS-1:0] center [NUM_AXES];
  logic [HALF_BITS-1:0]         half [NUM_AXES];
  logic [1:0]                   op_q;
  logic [HALF_BITS-1:0]         radius_q;
  logic [NUM_PLANES-1:0]        outside;
  logic [NUM_PLANES-1:0]        crossing;
  verdict_e                     verdict_d, verdict_q;

  fcull_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .planes_o (planes)
  );

  fcull_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_ready_i (result_o.ready),
    .ctl_o       (ctl)
  );

  assign center[0] = item_i.center_x;
  assign center[1] = item_i.center_y;
  assign center[2] = item_i.center_z;
  assign half[0]   = item_i.half_x;
  assign half[1]   = item_i.half_y;
  assign half[2]   = item_i.half_z;

  // The test kind and radius are needed by the sum stage, one step behind
  // the products, so they ride along in the multiply stage.
  always_ff @(posedge clk_i) begin
    if (ctl.ld[STG_MUL]) begin
      op_q     <= item_i.operation;
      radius_q <= item_i.radius;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fcull_plane_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .plane_i   (planes[p]),
      .center_i  (center),
      .half_i    (half),
      .op_i      (op_q),
      .radius_i  (radius_q),
      .outside_o (outside[p]),
      .cross_o   (crossing[p])
    );
  end

  // Any plane with the whole object behind it rejects it; otherwise any plane
  // with part of it behind makes the object straddle the frustum.
  always_comb begin
    if (|outside) begin
      verdict_d = VERDICT_OUTSIDE;
    end else if (|crossing) begin
      verdict_d = VERDICT_INTERSECT;
    end else begin
      verdict_d = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld[STG_OUT]) begin
      verdict_q <= verdict_d;
    end
  end

  assign result_o.valid   = ctl.vld[STG_OUT];
  assign result_o.verdict = verdict_q;

endmodule
